// ----- hdl/bbfs_pkg.sv -----
// Shared constants, request codes, helper functions and control types for the
// bounded byte FIFO with end-of-stream flag.
// No dependencies; every other file except bbfs_ram imports this package.
package bbfs_pkg;

   localparam int DEPTH   = 64;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = 7;
   localparam int TYPE_W  = 3;
   localparam int BYTE_W  = 8;
   localparam int TOTAL_W = 32;

   localparam logic [TYPE_W-1:0] REQ_WRITE = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_READ  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_PEEK  = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_POP   = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_END   = 3'd4;

   localparam logic [CNT_W-1:0] CAPACITY_RESET = 7'd64;

   // controller -> datapath
   typedef struct packed {
      logic accept;  // request transfer this cycle
      logic emit;    // send the next streamed byte
   } bbfs_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;      // output register can load this cycle
      logic start_stream;  // incoming request is a read/peek with bytes to send
      logic stream_last;   // one byte left in the current stream
   } bbfs_status_type;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] total,
                                                  input logic [CNT_W-1:0] amount);
      logic [TOTAL_W:0] sum;
      sum = {1'b0, total} + {{(TOTAL_W + 1 - CNT_W){1'b0}}, amount};
      return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
   endfunction

endpackage

// ----- hdl/bbfs_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on bbfs_pkg for field widths.
interface bbfs_req_if import bbfs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TYPE_W-1:0]   req_type;
   logic [BYTE_W-1:0]   write_byte;
   logic [CNT_W-1:0]    length;

   modport source (output valid, req_type, write_byte, length, input ready);
   modport sink   (input valid, req_type, write_byte, length, output ready);
endinterface

interface bbfs_rsp_if import bbfs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   data_byte;
   logic                byte_valid;
   logic                last;
   logic                accepted;
   logic [CNT_W-1:0]    fill_count;
   logic                ended;
   logic                end_of_stream;
   logic [TOTAL_W-1:0]  total_written;
   logic [TOTAL_W-1:0]  total_read;

   modport source (output valid, data_byte, byte_valid, last, accepted, fill_count,
                   ended, end_of_stream, total_written, total_read,
                   input ready);
   modport sink   (input valid, data_byte, byte_valid, last, accepted, fill_count,
                   ended, end_of_stream, total_written, total_read,
                   output ready);
endinterface

// ----- hdl/bounded_byte_fifo_stream.sv -----
// Bounded byte FIFO with end-of-input flag: top level joining sequencer and datapath.
// Depends on bbfs_pkg, bbfs_if, bbfs_ctrl and bbfs_datapath.
//
// Holds up to min(capacity, 64) bytes. A write, pop, end-input or unknown request
// gives one status result. A read or peek of n bytes (n cut to the fill) first takes
// the request and starts the byte store's registered read, then gives one byte result
// per cycle while the output register is free. An empty read or peek gives one status
// result. Results sit in an output register; a stalled result holds the block, and a
// new request is taken in the same cycle the waiting result transfers. The byte
// store has no reset and needs no clearing pass. Capacity is to be written through
// csr_ only while idle; the block itself does not enforce this.
module bounded_byte_fifo_stream import bbfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   bbfs_req_if.sink         req_chan,
   bbfs_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   bbfs_cmd_type    cmd;
   bbfs_status_type status;
   logic            req_ready;

   assign req_chan.ready = req_ready;

   bbfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bbfs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_type    (req_chan.req_type),
      .write_byte  (req_chan.write_byte),
      .length      (req_chan.length),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_chan    (rsp_chan)
   );

endmodule

// ----- hdl/bbfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/bbfs_ctrl.sv -----
// Request sequencer: accepts requests and paces the byte stream of a read or peek.
// Depends on bbfs_pkg; drives the datapath through bbfs_cmd_type.
module bbfs_ctrl import bbfs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  bbfs_status_type status,
   output bbfs_cmd_type    cmd
);

   localparam logic [0:0] ST_IDLE   = 1'b0;
   localparam logic [0:0] ST_STREAM = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.emit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = status.out_free;
            cmd.accept = req_valid && status.out_free;
            if (cmd.accept && status.start_stream) begin
               state_in = ST_STREAM;
            end
         end
         ST_STREAM: begin
            cmd.emit = status.out_free;
            if (cmd.emit && status.stream_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/bbfs_datapath.sv -----
// FIFO pointers, counters, capacity register, byte store and result register.
// Depends on bbfs_pkg, bbfs_if and bbfs_ram; commanded by bbfs_ctrl.
module bbfs_datapath import bbfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [TYPE_W-1:0] req_type,
   input  logic [BYTE_W-1:0] write_byte,
   input  logic [CNT_W-1:0]  length,
   input  logic              csr_wr_en,
   input  logic [CNT_W-1:0]  csr_wr_data,
   input  bbfs_cmd_type      cmd,
   output bbfs_status_type   status,
   bbfs_rsp_if.source        rsp_chan
);

   logic [IDX_W-1:0]   head_ff, head_in, tail_ff, tail_in, rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   held_ff, held_in, remain_ff, remain_in, capacity_ff;
   logic               ended_ff, ended_in, peek_ff, peek_in;
   logic [TOTAL_W-1:0] written_ff, written_in, read_ff, read_in;

   logic [CNT_W-1:0]   cap_eff, take_n;
   logic [CNT_W:0]     pop_sum;
   logic [IDX_W-1:0]   pop_head;
   logic               write_ok;
   logic               ram_wr_en;
   logic [BYTE_W-1:0]  ram_rd_data;

   logic               load;
   logic [BYTE_W-1:0]  out_data;
   logic               out_byte_valid, out_last, out_accepted;

   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  rsp_data_ff;
   logic               rsp_byte_valid_ff, rsp_last_ff, rsp_accepted_ff;
   logic               rsp_ended_ff, rsp_eos_ff;
   logic [CNT_W-1:0]   rsp_fill_ff;
   logic [TOTAL_W-1:0] rsp_written_ff, rsp_read_ff;

   assign cap_eff  = (capacity_ff > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity_ff;
   assign take_n   = (length < held_ff) ? length : held_ff;
   assign write_ok = !ended_ff && (held_ff < cap_eff);

   // head + n stays below twice the depth, so one subtract wraps it
   assign pop_sum  = {{(CNT_W + 1 - IDX_W){1'b0}}, head_ff} + {1'b0, take_n};
   always_comb begin
      if (pop_sum >= (CNT_W + 1)'(DEPTH)) begin
         pop_head = IDX_W'(pop_sum - (CNT_W + 1)'(DEPTH));
      end else begin
         pop_head = pop_sum[IDX_W-1:0];
      end
   end

   assign status.out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign status.start_stream = ((req_type == REQ_READ) || (req_type == REQ_PEEK))
                                && (take_n != '0);
   assign status.stream_last  = (remain_ff == CNT_W'(1));

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      held_in        = held_ff;
      ended_in       = ended_ff;
      written_in     = written_ff;
      read_in        = read_ff;
      remain_in      = remain_ff;
      rd_idx_in      = rd_idx_ff;
      peek_in        = peek_ff;
      ram_wr_en      = 1'b0;
      load           = 1'b0;
      out_data       = '0;
      out_byte_valid = 1'b0;
      out_last       = 1'b0;
      out_accepted   = 1'b0;
      if (cmd.accept) begin
         unique case (req_type)
            REQ_WRITE: begin
               load         = 1'b1;
               out_last     = 1'b1;
               out_accepted = write_ok;
               if (write_ok) begin
                  ram_wr_en  = 1'b1;
                  tail_in    = next_idx(tail_ff);
                  held_in    = held_ff + 1'b1;
                  written_in = sat_add(written_ff, CNT_W'(1));
               end
            end
            REQ_READ, REQ_PEEK: begin
               if (take_n == '0) begin
                  load     = 1'b1;
                  out_last = 1'b1;
               end else begin
                  remain_in = take_n;
                  rd_idx_in = head_ff;
                  peek_in   = (req_type == REQ_PEEK);
               end
            end
            REQ_POP: begin
               load     = 1'b1;
               out_last = 1'b1;
               head_in  = pop_head;
               held_in  = held_ff - take_n;
               read_in  = sat_add(read_ff, take_n);
            end
            REQ_END: begin
               load     = 1'b1;
               out_last = 1'b1;
               ended_in = 1'b1;
            end
            default: begin
               load     = 1'b1;
               out_last = 1'b1;
            end
         endcase
      end else if (cmd.emit) begin
         load           = 1'b1;
         out_data       = ram_rd_data;
         out_byte_valid = 1'b1;
         out_last       = (remain_ff == CNT_W'(1));
         remain_in      = remain_ff - 1'b1;
         rd_idx_in      = next_idx(rd_idx_ff);
         if (!peek_ff) begin
            head_in = next_idx(rd_idx_ff);
            held_in = held_ff - 1'b1;
            read_in = sat_add(read_ff, CNT_W'(1));
         end
      end
   end

   // read address follows the next stream index, so the data lines up with rd_idx_ff
   bbfs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (write_byte),
      .rd_addr (rd_idx_in),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         held_ff      <= '0;
         ended_ff     <= 1'b0;
         written_ff   <= '0;
         read_ff      <= '0;
         remain_ff    <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         held_ff    <= held_in;
         ended_ff   <= ended_in;
         written_ff <= written_in;
         read_ff    <= read_in;
         remain_ff  <= remain_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      peek_ff   <= peek_in;
      if (load) begin
         rsp_data_ff       <= out_data;
         rsp_byte_valid_ff <= out_byte_valid;
         rsp_last_ff       <= out_last;
         rsp_accepted_ff   <= out_accepted;
         rsp_fill_ff       <= held_in;
         rsp_ended_ff      <= ended_in;
         rsp_eos_ff        <= ended_in && (held_in == '0);
         rsp_written_ff    <= written_in;
         rsp_read_ff       <= read_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.data_byte     = rsp_data_ff;
   assign rsp_chan.byte_valid    = rsp_byte_valid_ff;
   assign rsp_chan.last          = rsp_last_ff;
   assign rsp_chan.accepted      = rsp_accepted_ff;
   assign rsp_chan.fill_count    = rsp_fill_ff;
   assign rsp_chan.ended         = rsp_ended_ff;
   assign rsp_chan.end_of_stream = rsp_eos_ff;
   assign rsp_chan.total_written = rsp_written_ff;
   assign rsp_chan.total_read    = rsp_read_ff;

endmodule

// ----- hdl/bbfs_checker.sv -----
// Port-level checks on the result channel of the byte FIFO, bound to the top level.
// Depends on bbfs_pkg and bounded_byte_fifo_stream.
module bbfs_checker import bbfs_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [BYTE_W-1:0]  rsp_data_byte,
   input logic               rsp_byte_valid,
   input logic               rsp_last,
   input logic               rsp_accepted,
   input logic [CNT_W-1:0]   rsp_fill_count,
   input logic               rsp_ended,
   input logic               rsp_end_of_stream
);

   logic seen_ended_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ended_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_ended) begin
         seen_ended_ff <= 1'b1;
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
                                  && $stable(rsp_last) && $stable(rsp_fill_count))
      else $error("result changed while stalled");

   a_eos_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_end_of_stream == (rsp_ended && (rsp_fill_count == '0)))
                    && (rsp_fill_count <= CNT_W'(DEPTH)))
      else $error("end of stream or fill count inconsistent");

   // ended flag is sticky once reported
   a_ended_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ended_ff |-> rsp_ended)
      else $error("input ended flag dropped");

   a_accept_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_last && !rsp_byte_valid)
      else $error("accepted write result carries a byte or is not last");

endmodule

bind bounded_byte_fifo_stream bbfs_checker u_bbfs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_data_byte     (rsp_chan.data_byte),
   .rsp_byte_valid    (rsp_chan.byte_valid),
   .rsp_last          (rsp_chan.last),
   .rsp_accepted      (rsp_chan.accepted),
   .rsp_fill_count    (rsp_chan.fill_count),
   .rsp_ended         (rsp_chan.ended),
   .rsp_end_of_stream (rsp_chan.end_of_stream)
);
